// File: rtl/lcbb_pkg.sv
// shared types, constants and command codes for the lru byte budget cache
package lcbb_pkg;
    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W = 32;
    localparam int HANDLE_W = 32;
    localparam int CNT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 88;
    localparam int IN_TUSER_W = 4;
    localparam int OUT_TDATA_W = 176;
    localparam int OUT_TUSER_W = 1;
    localparam logic [4:0] RESET_LIMIT = 5'd16;
    localparam logic [31:0] RESET_BUDGET = 32'd1048576;

    typedef enum logic [2:0] {
        CMD_GET   = 3'd0,
        CMD_PUT   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_RSTAT = 3'd3,
        CMD_TRIM  = 3'd4
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_LIMIT  = 1'b0,
        CFG_BUDGET = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_DECIDE,
        ST_TOUCH,
        ST_INSERT,
        ST_CHECK,
        ST_EVSCAN,
        ST_EVICT,
        ST_DONE
    } t_state;
endpackage

// File: rtl/lcbb_core.sv
// slot table with a sequencer that visits one slot per cycle
module lcbb_core #(
    parameter int CAPACITY = lcbb_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_ack,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [31:0] i_handle,
    input  logic [11:0] i_width,
    input  logic [11:0] i_height,
    input  logic        i_ok,
    input  logic [4:0]  i_limit,
    input  logic [31:0] i_budget,
    output logic        o_busy,
    output logic        o_done,
    output logic        o_hit,
    output logic [31:0] o_found,
    output logic [4:0]  o_count,
    output logic [31:0] o_bytes,
    output logic [31:0] o_hits,
    output logic [31:0] o_misses,
    output logic [31:0] o_evictions,
    output logic [4:0]  o_evicted
);
    import lcbb_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int EW = $clog2(CAPACITY + 2);
    localparam int TW = (26 + NW > 32) ? 26 + NW : 32;

    t_state r_st, n_st;
    logic [CAPACITY-1:0] r_valid;
    logic [31:0] r_key [CAPACITY];
    logic [31:0] r_hdl [CAPACITY];
    logic [25:0] r_sz [CAPACITY];
    logic [IW-1:0] r_age [CAPACITY];
    logic [TW-1:0] r_total;
    logic [NW-1:0] r_n;
    logic [31:0] r_hits, r_misses, r_evs;
    logic [IW-1:0] r_i;
    logic r_found;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_sage;
    logic r_vic_ok;
    logic [IW-1:0] r_vic;
    logic r_free_ok;
    logic [IW-1:0] r_free;
    logic [25:0] r_newsz;
    logic [EW-1:0] r_evn;
    logic r_hit;
    logic [31:0] r_fh;
    logic [2:0] r_cmd;
    logic [31:0] r_k, r_h;
    logic [11:0] r_w, r_hh;
    logic r_ok;

    logic last;
    logic [NW-1:0] lim;
    logic over;
    logic [23:0] prod;

    assign last = (r_i == IW'(CAPACITY - 1));
    assign lim = (32'(i_limit) > 32'(CAPACITY)) ? NW'(CAPACITY) : NW'(i_limit);
    assign over = (r_n > lim) || (r_total > TW'(i_budget));
    assign prod = r_w * r_hh;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_start) n_st = ST_MUL;
            ST_MUL: begin
                case (r_cmd)
                    CMD_GET: n_st = ST_SCAN;
                    CMD_PUT: n_st = r_ok ? ST_SCAN : ST_DONE;
                    CMD_TRIM: n_st = ST_CHECK;
                    default: n_st = ST_DONE;
                endcase
            end
            ST_SCAN: if (last) n_st = ST_DECIDE;
            ST_DECIDE: begin
                if (r_found) n_st = ST_TOUCH;
                else if (r_cmd == CMD_GET) n_st = ST_DONE;
                else if (!r_free_ok) n_st = ST_EVSCAN;
                else n_st = ST_INSERT;
            end
            ST_TOUCH: if (last) n_st = (r_cmd == CMD_GET) ? ST_DONE : ST_CHECK;
            ST_INSERT: if (last) n_st = ST_CHECK;
            ST_CHECK: n_st = (over && r_n != '0) ? ST_EVSCAN : ST_DONE;
            ST_EVSCAN: if (last) n_st = ST_EVICT;
            ST_EVICT: n_st = (r_cmd == CMD_PUT && !r_found && !r_free_ok) ?
                             ST_INSERT : ST_CHECK;
            ST_DONE: if (i_ack) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_total <= '0;
            r_n <= '0;
            r_hits <= '0;
            r_misses <= '0;
            r_evs <= '0;
        end else begin
            case (r_st)
                ST_IDLE: if (i_start) begin
                    r_cmd <= i_cmd; r_k <= i_key; r_h <= i_handle;
                    r_w <= i_width; r_hh <= i_height; r_ok <= i_ok;
                    r_i <= '0; r_found <= 1'b0; r_free_ok <= 1'b0;
                    r_evn <= '0; r_hit <= 1'b0; r_fh <= '0;
                end
                ST_MUL: begin
                    r_newsz <= {prod, 2'b00};
                    if (r_cmd == CMD_CLEAR) begin
                        r_valid <= '0; r_total <= '0; r_n <= '0;
                    end
                    if (r_cmd == CMD_RSTAT) begin
                        r_hits <= '0; r_misses <= '0; r_evs <= '0;
                    end
                end
                ST_SCAN: begin
                    if (r_valid[r_i] && r_key[r_i] == r_k && !r_found) begin
                        r_found <= 1'b1; r_slot <= r_i;
                    end
                    if (!r_valid[r_i] && !r_free_ok) begin
                        r_free_ok <= 1'b1; r_free <= r_i;
                    end
                    r_i <= last ? '0 : r_i + 1'b1;
                end
                ST_DECIDE: begin
                    r_i <= '0;
                    r_vic_ok <= 1'b0;
                    if (r_found) begin
                        r_sage <= r_age[r_slot];
                        if (r_cmd == CMD_GET) begin
                            r_hits <= r_hits + 1'b1; r_hit <= 1'b1;
                            r_fh <= r_hdl[r_slot];
                        end else begin
                            r_total <= r_total - TW'(r_sz[r_slot]) + TW'(r_newsz);
                            r_hdl[r_slot] <= r_h;
                            r_sz[r_slot] <= r_newsz;
                        end
                    end else if (r_cmd == CMD_GET) begin
                        r_misses <= r_misses + 1'b1;
                    end
                end
                ST_TOUCH: begin
                    if (r_i == r_slot) r_age[r_i] <= '0;
                    else if (r_valid[r_i] && r_age[r_i] < r_sage)
                        r_age[r_i] <= r_age[r_i] + 1'b1;
                    r_i <= last ? '0 : r_i + 1'b1;
                end
                ST_INSERT: begin
                    if (r_i == r_free) begin
                        r_valid[r_i] <= 1'b1; r_key[r_i] <= r_k;
                        r_hdl[r_i] <= r_h; r_sz[r_i] <= r_newsz;
                        r_age[r_i] <= '0;
                    end else if (r_valid[r_i]) begin
                        r_age[r_i] <= r_age[r_i] + 1'b1;
                    end
                    if (last) begin
                        r_total <= r_total + TW'(r_newsz);
                        r_n <= r_n + 1'b1;
                    end
                    r_i <= last ? '0 : r_i + 1'b1;
                end
                ST_CHECK: begin
                    r_i <= '0; r_vic_ok <= 1'b0;
                end
                ST_EVSCAN: begin
                    if (r_valid[r_i] && (!r_vic_ok || r_age[r_i] > r_age[r_vic])) begin
                        r_vic_ok <= 1'b1; r_vic <= r_i;
                    end
                    r_i <= last ? '0 : r_i + 1'b1;
                end
                ST_EVICT: begin
                    r_valid[r_vic] <= 1'b0;
                    r_total <= r_total - TW'(r_sz[r_vic]);
                    r_n <= r_n - 1'b1;
                    r_evs <= r_evs + 1'b1;
                    r_evn <= r_evn + 1'b1;
                    r_free_ok <= 1'b1; r_free <= r_vic;
                    r_i <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_st != ST_IDLE);
    assign o_done = (r_st == ST_DONE);
    assign o_hit = r_hit;
    assign o_found = r_fh;
    assign o_count = (r_n > NW'(31)) ? 5'd31 : 5'(r_n);
    assign o_bytes = (r_total > TW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(r_total);
    assign o_hits = r_hits;
    assign o_misses = r_misses;
    assign o_evictions = r_evs;
    assign o_evicted = (r_evn > EW'(31)) ? 5'd31 : 5'(r_evn);
endmodule

// File: rtl/lru_cache_with_byte_budget_core.sv
// top level: stream ports, config registers, output register
// steps: a size multiply; clear, stat reset, unused or dropped put then finish; get and put
// scan every slot, then a hit runs a touch pass and a put miss an insert pass, after one
// eviction when full; put and trim then evict the oldest entry while over limit or budget
// throughput: one beat at a time; the next beat can be taken in the cycle after the result is
// registered, the core holds its result while the output register is still full
// reset: synchronous active low; table empty, counters zero, limit 16, budget 1048576
module lru_cache_with_byte_budget_core #(
    parameter int CAPACITY = lcbb_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lookup_key, payload_handle, image_width, image_height
    input  logic [lcbb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // command, image_ok
    input  logic [lcbb_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found_handle, entries held, bytes_held, hits_total, misses_total,
    // evictions_total, evicted_now
    output logic [lcbb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // hit
    output logic [lcbb_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [lcbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lcbb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcbb_pkg::*;

    logic [4:0] r_limit;
    logic [31:0] r_budget;
    logic r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic [OUT_TUSER_W-1:0] r_ouser;
    logic busy, done, hit;
    logic [31:0] fh, bytes, hits, misses, evs;
    logic [4:0] cnt, evn;
    logic start;
    logic load;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;
    assign load = done && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= RESET_LIMIT;
            r_budget <= RESET_BUDGET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LIMIT: r_limit <= i_cfg_data[4:0];
                CFG_BUDGET: r_budget <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcbb_core #(.CAPACITY(CAPACITY)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_ack(load),
        .i_cmd(s_axis_tuser[2:0]), .i_key(s_axis_tdata[31:0]),
        .i_handle(s_axis_tdata[63:32]), .i_width(s_axis_tdata[75:64]),
        .i_height(s_axis_tdata[87:76]), .i_ok(s_axis_tuser[3]),
        .i_limit(r_limit), .i_budget(r_budget),
        .o_busy(busy), .o_done(done), .o_hit(hit), .o_found(fh),
        .o_count(cnt), .o_bytes(bytes), .o_hits(hits), .o_misses(misses),
        .o_evictions(evs), .o_evicted(evn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
            r_odata <= {6'b000000, evn, evs, misses, hits, bytes, cnt, fh};
            r_ouser <= hit;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready) else $error("accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat dropped");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("beat changed while stalled");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy) else $error("sequencer did not start");
endmodule
